FILE: src/dnmps_pkg.sv
// ----------------------------------------------------------------------------
// dnmps_pkg
// Shared constants and helper functions for the day/night map pixel shader.
// ----------------------------------------------------------------------------
package dnmps_pkg;

    localparam int MAP_WIDTH  = 320;
    localparam int MAP_HEIGHT = 240;

    localparam int NUM_STAGES = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWILIGHT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ENABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_SIN_DECL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_COS_DECL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_SIN_LON   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_COS_LON   = 3'd6;

    localparam logic signed [15:0] SUN_ZERO = 16'sd0;
    localparam logic signed [15:0] SUN_ONE  = 16'sd16384;

    localparam logic [15:0] WATER_COLOR     = 16'h0911;
    localparam logic [15:0] LAND_COLOR      = 16'h5CE9;
    localparam logic [4:0]  WATER_RED_LIMIT = 5'd6;

    localparam logic [7:0] NIGHT_FACTOR = 8'd64;
    localparam logic [7:0] RAMP_MAX_Q   = 8'd191;

    localparam int TWI_K_INT = 3406;
    localparam logic [11:0] TWI_K          = 12'(TWI_K_INT);
    localparam logic [19:0] TWI_K_EXT      = 20'(TWI_K_INT);
    localparam logic [19:0] TWI_REM_LIMIT  = 20'(2 * TWI_K_INT);
    localparam logic signed [63:0] TWI_OFFSET = 64'sd3406 <<< 42;
    localparam logic [20:0] TWI_RECIP      = 21'd1261000;

    localparam logic [8:0] GRID_COLS [11] =
        '{9'd27, 9'd53, 9'd80, 9'd107, 9'd133, 9'd160, 9'd187, 9'd213, 9'd240,
          9'd267, 9'd293};
    localparam logic [7:0] GRID_ROWS [5] = '{8'd40, 8'd80, 8'd120, 8'd160, 8'd200};

    function automatic logic is_grid_row(input logic [7:0] r);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (r == GRID_ROWS[i]) begin
                hit = 1'b1;
            end
        end
        return hit && (11'(r) < 11'(MAP_HEIGHT));
    endfunction

    function automatic logic is_grid_col(input logic [8:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 11; i++) begin
            if (c == GRID_COLS[i]) begin
                hit = 1'b1;
            end
        end
        return hit && (11'(c) < 11'(MAP_WIDTH));
    endfunction

    function automatic logic [15:0] blend_white(input logic [15:0] p);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] b;
        r = {1'b0, p[15:11]} + 6'd31;
        g = {1'b0, p[10:5]} + 7'd63;
        b = {1'b0, p[4:0]} + 6'd31;
        return {r[5:1], g[6:1], b[5:1]};
    endfunction

endpackage

FILE: src/day_night_map_pixel_shader.sv
// ----------------------------------------------------------------------------
// day_night_map_pixel_shader
// Throughput: one pixel per cycle while out_stall is low, through a ten-stage
// pipeline built around the sun elevation multipliers and the twilight reciprocal divide.
// Reset clears all pipeline valid bits and loads the configuration defaults.
// Recolors, grid-blends and day/night dims one RGB565 map pixel per beat.
// ----------------------------------------------------------------------------
module day_night_map_pixel_shader (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dnmps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dnmps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [15:0]                          src_pixel,
    input  logic [8:0]                           column,
    input  logic [7:0]                           row,
    input  logic signed [15:0]                   row_sin_lat,
    input  logic signed [15:0]                   row_cos_lat,
    input  logic signed [15:0]                   col_cos_lon,
    input  logic signed [15:0]                   col_sin_lon,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          out_pixel
);
    import dnmps_pkg::*;

    logic                    map_mode_reg;
    logic                    twilight_mode_reg;
    logic                    grid_enable_reg;
    logic signed [15:0]      sun_sin_decl_reg;
    logic signed [15:0]      sun_cos_decl_reg;
    logic signed [15:0]      sun_sin_lon_reg;
    logic signed [15:0]      sun_cos_lon_reg;

    logic [NUM_STAGES-1:0]   v_reg;
    logic [NUM_STAGES-1:0]   en;

    logic [15:0]             pix0_reg, pix1_reg, pix2_reg, pix3_reg, pix4_reg;
    logic [15:0]             pix5_reg, pix6_reg, pix7_reg, pix8_reg, pix9_reg;
    logic signed [31:0]      a0_reg, b0_reg, p0a_reg, p0b_reg;
    logic signed [31:0]      a1_reg, b1_reg, a2_reg;
    logic signed [32:0]      t1_reg;
    logic signed [63:0]      bt2_reg, s3_reg;
    logic                    neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic                    le4_reg, le5_reg, le6_reg, le7_reg;
    logic [53:0]             d4_reg;
    logic [19:0]             m5_reg, m6_reg, m7_reg;
    logic [7:0]              qe6_reg, qe7_reg;
    logic [19:0]             pr7_reg;
    logic                    dim8_reg;
    logic [7:0]              f8_reg;

    logic [15:0]             pix0_next;
    logic [15:0]             recolor_w;
    logic                    grid_w;
    logic signed [64:0]      bt_w;
    logic signed [63:0]      s3_next;
    logic signed [63:0]      d_w;
    logic [55:0]             d3_w;
    logic [40:0]             recip_w;
    logic [19:0]             rem_w;
    logic [7:0]              q_w;
    logic                    ramp_w;
    logic [7:0]              f8_next;
    logic [12:0]             rp_w;
    logic [13:0]             gp_w;
    logic [12:0]             bp_w;
    logic [15:0]             pix9_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg      <= 1'b0;
            twilight_mode_reg <= 1'b0;
            grid_enable_reg   <= 1'b0;
            sun_sin_decl_reg  <= SUN_ZERO;
            sun_cos_decl_reg  <= SUN_ONE;
            sun_sin_lon_reg   <= SUN_ZERO;
            sun_cos_lon_reg   <= SUN_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAP_MODE:      map_mode_reg      <= cfg_data[0];
                CFG_TWILIGHT_MODE: twilight_mode_reg <= cfg_data[0];
                CFG_GRID_ENABLE:   grid_enable_reg   <= cfg_data[0];
                CFG_SUN_SIN_DECL:  sun_sin_decl_reg  <= cfg_data;
                CFG_SUN_COS_DECL:  sun_cos_decl_reg  <= cfg_data;
                CFG_SUN_SIN_LON:   sun_sin_lon_reg   <= cfg_data;
                CFG_SUN_COS_LON:   sun_cos_lon_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a new beat when it is empty or when the stage after it moves.
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NUM_STAGES-1];
    assign out_pixel = pix9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        recolor_w = src_pixel;
        if (map_mode_reg)
        begin
            recolor_w = (src_pixel[15:11] < WATER_RED_LIMIT) ? WATER_COLOR : LAND_COLOR;
        end
        grid_w    = grid_enable_reg && (is_grid_row(row) || is_grid_col(column));
        pix0_next = grid_w ? blend_white(recolor_w) : recolor_w;
    end

    assign bt_w    = b1_reg * t1_reg;
    assign s3_next = (64'(a2_reg) <<< 28) + bt2_reg;
    assign d_w     = s3_reg + TWI_OFFSET;
    assign d3_w    = {2'b00, d4_reg} + {1'b0, d4_reg, 1'b0};
    assign recip_w = m5_reg * TWI_RECIP;
    assign rem_w   = m7_reg - pr7_reg;
    assign q_w     = qe7_reg + 8'(rem_w >= TWI_K_EXT);
    assign ramp_w  = neg7_reg && twilight_mode_reg && !le7_reg;
    assign f8_next = ramp_w ? (NIGHT_FACTOR + q_w) : NIGHT_FACTOR;

    assign rp_w = pix8_reg[15:11] * f8_reg;
    assign gp_w = pix8_reg[10:5] * f8_reg;
    assign bp_w = pix8_reg[4:0] * f8_reg;
    assign pix9_next = dim8_reg ? {rp_w[12:8], gp_w[13:8], bp_w[12:8]} : pix8_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pix0_reg <= pix0_next;
            a0_reg   <= row_sin_lat * sun_sin_decl_reg;
            b0_reg   <= row_cos_lat * sun_cos_decl_reg;
            p0a_reg  <= sun_cos_lon_reg * col_cos_lon;
            p0b_reg  <= sun_sin_lon_reg * col_sin_lon;
        end
        if (en[1])
        begin
            pix1_reg <= pix0_reg;
            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            t1_reg   <= 33'(p0a_reg) + 33'(p0b_reg);
        end
        if (en[2])
        begin
            pix2_reg <= pix1_reg;
            a2_reg   <= a1_reg;
            bt2_reg  <= bt_w[63:0];
        end
        if (en[3])
        begin
            pix3_reg <= pix2_reg;
            s3_reg   <= s3_next;
        end
        if (en[4])
        begin
            pix4_reg <= pix3_reg;
            neg4_reg <= s3_reg[63];
            le4_reg  <= d_w[63] || (d_w == '0);
            d4_reg   <= d_w[53:0];
        end
        if (en[5])
        begin
            pix5_reg <= pix4_reg;
            neg5_reg <= neg4_reg;
            le5_reg  <= le4_reg;
            m5_reg   <= d3_w[55:36];
        end
        if (en[6])
        begin
            pix6_reg <= pix5_reg;
            neg6_reg <= neg5_reg;
            le6_reg  <= le5_reg;
            m6_reg   <= m5_reg;
            qe6_reg  <= recip_w[39:32];
        end
        if (en[7])
        begin
            pix7_reg <= pix6_reg;
            neg7_reg <= neg6_reg;
            le7_reg  <= le6_reg;
            m7_reg   <= m6_reg;
            qe7_reg  <= qe6_reg;
            pr7_reg  <= qe6_reg * TWI_K;
        end
        if (en[8])
        begin
            pix8_reg <= pix7_reg;
            dim8_reg <= neg7_reg;
            f8_reg   <= f8_next;
        end
        if (en[9])
        begin
            pix9_reg <= pix9_next;
        end
    end

    // An empty output stage always lets a new pixel in.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output stage is empty");

    // The input side stalls only when every stage holds a beat.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    // The reciprocal estimate is at most one below the true quotient, and the ramp quotient stays within RAMP_MAX_Q.
    a_ramp_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[7] && ramp_w) |-> (rem_w < TWI_REM_LIMIT && q_w <= RAMP_MAX_Q))
        else $error("twilight ramp quotient out of range");

endmodule

FILE: tb/day_night_map_pixel_shader_tb.sv
// ----------------------------------------------------------------------------
// day_night_map_pixel_shader_tb
// Self-checking bench for the day/night map pixel shader. Each accepted pixel
// beat is shaded by a local predictor using the bench's own copy of the
// configuration. Every output beat is checked against the oldest prediction.
// Directed beats cover recolor, grid lines and the twilight ramp. Random
// phases then run under several settings while both sides idle at random.
// ----------------------------------------------------------------------------
module day_night_map_pixel_shader_tb;

    localparam int MAP_COLUMNS        = 320;
    localparam int MAP_ROWS           = 240;
    localparam logic [15:0] WATER_PIXEL = 16'h0911;
    localparam logic [15:0] LAND_PIXEL  = 16'h5CE9;
    localparam logic [4:0] WATER_RED_LIMIT = 5'd6;
    localparam int NIGHT_FACTOR       = 64;
    localparam int RAMP_SPAN          = 192;
    localparam int FULL_FACTOR        = 256;
    localparam int TWILIGHT_LIMIT_Q14 = 3406;
    localparam logic [8:0] GRID_COLUMN_LIST [11] =
        '{9'd27, 9'd53, 9'd80, 9'd107, 9'd133, 9'd160, 9'd187, 9'd213, 9'd240,
          9'd267, 9'd293};
    localparam logic [7:0] GRID_ROW_LIST [5] = '{8'd40, 8'd80, 8'd120, 8'd160, 8'd200};
    localparam logic [dnmps_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int SETTLE_CYCLES    = dnmps_pkg::NUM_STAGES + 6;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT   = 2000;

    typedef struct {
        logic [15:0]        src_pixel;
        logic [8:0]         column;
        logic [7:0]         row;
        logic signed [15:0] row_sin_lat;
        logic signed [15:0] row_cos_lat;
        logic signed [15:0] col_cos_lon;
        logic signed [15:0] col_sin_lon;
    } pixel_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [dnmps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dnmps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [15:0] src_pixel;
    logic [8:0] column;
    logic [7:0] row;
    logic signed [15:0] row_sin_lat;
    logic signed [15:0] row_cos_lat;
    logic signed [15:0] col_cos_lon;
    logic signed [15:0] col_sin_lon;
    logic out_valid;
    logic out_stall;
    logic [15:0] out_pixel;

    logic cfg_map_mode;
    logic cfg_twilight_mode;
    logic cfg_grid_enable;
    logic signed [15:0] cfg_sun_sin_decl;
    logic signed [15:0] cfg_sun_cos_decl;
    logic signed [15:0] cfg_sun_sin_lon;
    logic signed [15:0] cfg_sun_cos_lon;

    logic [15:0] expected_pixels [$];
    int mismatches = 0;
    int stuck_cycles = 0;
    bit sender_idling = 1'b1;
    bit quiet_tail = 1'b0;
    bit hold_output = 1'b0;

    always #1 clk = ~clk;

    day_night_map_pixel_shader dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_pixel   (src_pixel),
        .column      (column),
        .row         (row),
        .row_sin_lat (row_sin_lat),
        .row_cos_lat (row_cos_lat),
        .col_cos_lon (col_cos_lon),
        .col_sin_lon (col_sin_lon),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_pixel   (out_pixel)
    );

    function automatic logic [15:0] shade_pixel(input pixel_beat_t beat);
        logic [15:0] pix;
        logic [5:0] red_sum;
        logic [6:0] green_sum;
        logic [5:0] blue_sum;
        longint lat_term;
        longint decl_term;
        longint elevation;
        longint night_limit;
        longint unsigned ramp_num;
        longint unsigned ramp_den;
        int unsigned factor;
        bit on_grid;
        pix = beat.src_pixel;
        if (cfg_map_mode)
        begin
            pix = (pix[15:11] < WATER_RED_LIMIT) ? WATER_PIXEL : LAND_PIXEL;
        end
        lat_term  = longint'(beat.row_sin_lat) * longint'(cfg_sun_sin_decl);
        decl_term = longint'(beat.row_cos_lat) * longint'(cfg_sun_cos_decl);
        elevation = (lat_term <<< 28)
                  + decl_term * (longint'(cfg_sun_cos_lon) * longint'(beat.col_cos_lon)
                               + longint'(cfg_sun_sin_lon) * longint'(beat.col_sin_lon));
        factor = FULL_FACTOR;
        if (elevation < 0)
        begin
            night_limit = -(longint'(TWILIGHT_LIMIT_Q14) <<< 42);
            if (!cfg_twilight_mode || elevation <= night_limit)
            begin
                factor = NIGHT_FACTOR;
            end
            else
            begin
                ramp_num = unsigned'(elevation - night_limit) * RAMP_SPAN;
                ramp_den = unsigned'(-night_limit);
                factor = NIGHT_FACTOR + 32'(ramp_num / ramp_den);
            end
        end
        on_grid = 1'b0;
        if (cfg_grid_enable)
        begin
            if (beat.row < MAP_ROWS)
            begin
                foreach (GRID_ROW_LIST[i])
                begin
                    if (beat.row == GRID_ROW_LIST[i])
                    begin
                        on_grid = 1'b1;
                    end
                end
            end
            if (beat.column < MAP_COLUMNS)
            begin
                foreach (GRID_COLUMN_LIST[i])
                begin
                    if (beat.column == GRID_COLUMN_LIST[i])
                    begin
                        on_grid = 1'b1;
                    end
                end
            end
        end
        if (on_grid)
        begin
            red_sum   = {1'b0, pix[15:11]} + 6'd31;
            green_sum = {1'b0, pix[10:5]} + 7'd63;
            blue_sum  = {1'b0, pix[4:0]} + 6'd31;
            pix = {red_sum[5:1], green_sum[6:1], blue_sum[5:1]};
        end
        if (factor < FULL_FACTOR)
        begin
            pix = {5'((pix[15:11] * factor) >> 8), 6'((pix[10:5] * factor) >> 8),
                   5'((pix[4:0] * factor) >> 8)};
        end
        return pix;
    endfunction

    function automatic logic signed [15:0] random_trig();
        int value;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return -16'sd16384;
                    3: return 16'sd16384;
                    default: return 16'sd0;
                endcase
            end
            default:
            begin
                value = int'($urandom_range(0, 32768)) - 16384;
                return 16'(value);
            end
        endcase
    endfunction

    function automatic pixel_beat_t random_beat();
        pixel_beat_t beat;
        beat.src_pixel = 16'($urandom);
        case ($urandom_range(0, 7))
            0: beat.column = 9'($urandom);
            1, 2: beat.column = GRID_COLUMN_LIST[$urandom_range(0, 10)];
            default: beat.column = 9'($urandom_range(0, MAP_COLUMNS - 1));
        endcase
        case ($urandom_range(0, 7))
            0: beat.row = 8'($urandom);
            1, 2: beat.row = GRID_ROW_LIST[$urandom_range(0, 4)];
            default: beat.row = 8'($urandom_range(0, MAP_ROWS - 1));
        endcase
        beat.row_sin_lat = random_trig();
        beat.row_cos_lat = random_trig();
        beat.col_cos_lon = random_trig();
        beat.col_sin_lon = random_trig();
        return beat;
    endfunction

    function automatic pixel_beat_t make_beat(input logic [15:0] pix, input logic [8:0] col,
                                              input logic [7:0] r,
                                              input logic signed [15:0] slat,
                                              input logic signed [15:0] clat,
                                              input logic signed [15:0] ccol,
                                              input logic signed [15:0] scol);
        pixel_beat_t beat;
        beat.src_pixel   = pix;
        beat.column      = col;
        beat.row         = r;
        beat.row_sin_lat = slat;
        beat.row_cos_lat = clat;
        beat.col_cos_lon = ccol;
        beat.col_sin_lon = scol;
        return beat;
    endfunction

    task automatic send_pixel(input pixel_beat_t beat);
        if (sender_idling && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        src_pixel   <= beat.src_pixel;
        column      <= beat.column;
        row         <= beat.row;
        row_sin_lat <= beat.row_sin_lat;
        row_cos_lat <= beat.row_cos_lat;
        col_cos_lon <= beat.col_cos_lon;
        col_sin_lon <= beat.col_sin_lon;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        expected_pixels.push_back(shade_pixel(beat));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [dnmps_pkg::CFG_IDX_W-1:0] index,
                                input logic [15:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (index)
            dnmps_pkg::CFG_MAP_MODE:      cfg_map_mode = data[0];
            dnmps_pkg::CFG_TWILIGHT_MODE: cfg_twilight_mode = data[0];
            dnmps_pkg::CFG_GRID_ENABLE:   cfg_grid_enable = data[0];
            dnmps_pkg::CFG_SUN_SIN_DECL:  cfg_sun_sin_decl = data;
            dnmps_pkg::CFG_SUN_COS_DECL:  cfg_sun_cos_decl = data;
            dnmps_pkg::CFG_SUN_SIN_LON:   cfg_sun_sin_lon = data;
            dnmps_pkg::CFG_SUN_COS_LON:   cfg_sun_cos_lon = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [2:0] modes, input logic signed [15:0] ssd,
                                  input logic signed [15:0] scd,
                                  input logic signed [15:0] ssl,
                                  input logic signed [15:0] scl);
        set_register(dnmps_pkg::CFG_MAP_MODE, {15'($urandom), modes[0]});
        set_register(dnmps_pkg::CFG_TWILIGHT_MODE, {15'($urandom), modes[1]});
        set_register(dnmps_pkg::CFG_GRID_ENABLE, {15'($urandom), modes[2]});
        set_register(dnmps_pkg::CFG_SUN_SIN_DECL, ssd);
        set_register(dnmps_pkg::CFG_SUN_COS_DECL, scd);
        set_register(dnmps_pkg::CFG_SUN_SIN_LON, ssl);
        set_register(dnmps_pkg::CFG_SUN_COS_LON, scl);
    endtask

    task automatic test_default_sun();
        send_pixel(make_beat(16'hFFFF, 9'd0, 8'd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
        send_pixel(make_beat(16'h0000, 9'd511, 8'd255, 16'sd0, 16'sd16384, -16'sd16384,
                             16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd100, 8'd100, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                             16'sh8000));
        send_pixel(make_beat(16'h8410, 9'd1, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    endtask

    task automatic test_flat_recolor();
        wait_drained();
        set_register(dnmps_pkg::CFG_MAP_MODE, 16'h0001);
        send_pixel(make_beat(16'h2FFF, 9'd10, 8'd10, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
        send_pixel(make_beat(16'h3000, 9'd11, 8'd10, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
        send_pixel(make_beat(16'h0000, 9'd12, 8'd10, 16'sd0, 16'sd16384, -16'sd16384,
                             16'sd0));
        send_pixel(make_beat(16'hF800, 9'd13, 8'd10, 16'sd0, 16'sd16384, -16'sd16384,
                             16'sd0));
    endtask

    task automatic test_grid_lines();
        wait_drained();
        set_register(dnmps_pkg::CFG_MAP_MODE, 16'hFFFE);
        set_register(dnmps_pkg::CFG_GRID_ENABLE, 16'hFFFF);
        send_pixel(make_beat(16'h0000, 9'd0, 8'd40, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
        send_pixel(make_beat(16'h1234, 9'd319, 8'd200, 16'sd0, 16'sd16384, 16'sd16384,
                             16'sd0));
        send_pixel(make_beat(16'h8410, 9'd27, 8'd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd293, 8'd239, 16'sd0, 16'sd16384, 16'sd16384,
                             16'sd0));
        send_pixel(make_beat(16'h0000, 9'd511, 8'd255, 16'sd0, 16'sd16384, 16'sd16384,
                             16'sd0));
        send_pixel(make_beat(16'h0000, 9'd80, 8'd80, 16'sd0, 16'sd16384, -16'sd16384,
                             16'sd0));
        wait_drained();
        set_register(dnmps_pkg::CFG_GRID_ENABLE, 16'hFFFE);
        send_pixel(make_beat(16'h0000, 9'd27, 8'd40, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0));
    endtask

    task automatic test_twilight_ramp();
        wait_drained();
        set_register(dnmps_pkg::CFG_TWILIGHT_MODE, 16'h0001);
        set_register(dnmps_pkg::CFG_SUN_SIN_DECL, -16'sd3406);
        set_register(dnmps_pkg::CFG_SUN_COS_DECL, 16'sd0);
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd16384, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd16383, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd8192, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd1, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, -16'sd1, 16'sd0, 16'sd0, 16'sd0));
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0));
        wait_drained();
        set_register(dnmps_pkg::CFG_TWILIGHT_MODE, 16'h8000);
        set_register(CFG_UNUSED_INDEX, 16'hFFFF);
        send_pixel(make_beat(16'hFFFF, 9'd5, 8'd5, 16'sd1, 16'sd0, 16'sd0, 16'sd0));
    endtask

    task automatic test_output_backpressure();
        hold_output = 1'b1;
        sender_idling = 1'b0;
        repeat (40) send_pixel(random_beat());
        sender_idling = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                0: write_settings(3'b111, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
                1: write_settings(3'b000, -16'sd16384, -16'sd16384, -16'sd16384,
                                  -16'sd16384);
                2: write_settings(3'b110, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
                default: write_settings(3'($urandom), random_trig(), random_trig(),
                                        random_trig(), random_trig());
            endcase
            repeat (220) send_pixel(random_beat());
        end
    endtask

    task automatic test_steady_stream();
        wait_drained();
        write_settings(3'b011, random_trig(), random_trig(), random_trig(), random_trig());
        quiet_tail = 1'b1;
        repeat (200) send_pixel(random_beat());
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        logic [15:0] want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("out_pixel: expected no beat, actual %h", out_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_pixel !== want)
                begin
                    $error("out_pixel: expected %h, actual %h", want, out_pixel);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_map_mode      = 1'b0;
        cfg_twilight_mode = 1'b0;
        cfg_grid_enable   = 1'b0;
        cfg_sun_sin_decl  = 16'sd0;
        cfg_sun_cos_decl  = 16'sd16384;
        cfg_sun_sin_lon   = 16'sd0;
        cfg_sun_cos_lon   = 16'sd16384;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        src_pixel   <= '0;
        column      <= '0;
        row         <= '0;
        row_sin_lat <= '0;
        row_cos_lat <= '0;
        col_cos_lon <= '0;
        col_sin_lon <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_sun();
        test_flat_recolor();
        test_grid_lines();
        test_twilight_ramp();
        test_output_backpressure();
        test_random_settings();
        test_steady_stream();
        wait_drained();
        if (mismatches == 0 && expected_pixels.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
